### hw/rtl/sppc_pkg.sv
`timescale 1ns / 1ps

package sppc_pkg;

   localparam int CMD_W      = 3;
   localparam int DELTA_W    = 16;
   localparam int RATE_W     = 32;
   localparam int PROD_W     = DELTA_W + RATE_W;
   localparam int MODE_W     = 2;
   localparam int EVENT_W    = 2;
   localparam int LOOP_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PLAY    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FORWARD = 3'd4;
   localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SEEK    = 3'd6;

   localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

   localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
   localparam logic [EVENT_W-1:0] EV_STARTED = 2'd1;
   localparam logic [EVENT_W-1:0] EV_LOOPED  = 2'd2;
   localparam logic [EVENT_W-1:0] EV_ENDED   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SEG_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_MODE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATE = 2'd3;

   localparam logic [RATE_W-1:0] RATE_RESET = 32'd4295;

   typedef struct packed {
      logic load;
      logic calc;
      logic step;
      logic wrap;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_status_type;

endpackage

### hw/rtl/segment_playback_position_counter_core.sv
`timescale 1ns / 1ps

// Playback position counter, Q1.FRACTION_BITS. One command per transfer on req_*,
// one result per command on rsp_* holding the state after that command. An accepted
// command is latched into the operand registers, evaluated in the calc state and then
// moved into the output register once that is free; a tick that wraps in loop mode
// first passes through the bit-serial remainder unit, which works out the overshoot
// modulo the span, one dividend bit per cycle, and then through the wrap state. Commands
// are taken one at a time; the next command is accepted once the previous result has
// moved into the output register, which may still be waiting on rsp_stall. Segment
// and rate registers must be written on csr_* only while no command is in flight; the
// block itself does not enforce this.
module segment_playback_position_counter_core #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sppc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sppc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sppc_pkg::CMD_W-1:0]         req_command,
   input  logic [sppc_pkg::DELTA_W-1:0]       req_delta_time,
   input  logic [FRACTION_BITS:0]             req_seek_position,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [FRACTION_BITS:0]             rsp_position,
   output logic                               rsp_playing,
   output logic                               rsp_forward_dir,
   output logic [sppc_pkg::LOOP_W-1:0]        rsp_loop_total,
   output logic [sppc_pkg::EVENT_W-1:0]       rsp_event_res
);

   sppc_pkg::ctrl_cmd_type  cmd;
   sppc_pkg::dp_status_type status;

   sppc_ctrl #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sppc_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_command       (req_command),
      .req_delta_time    (req_delta_time),
      .req_seek_position (req_seek_position),
      .cmd               (cmd),
      .status            (status),
      .rsp_position      (rsp_position),
      .rsp_playing       (rsp_playing),
      .rsp_forward_dir   (rsp_forward_dir),
      .rsp_loop_total    (rsp_loop_total),
      .rsp_event_res     (rsp_event_res)
   );

endmodule

### hw/rtl/sppc_datapath.sv
`timescale 1ns / 1ps

module sppc_datapath #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [sppc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sppc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [sppc_pkg::CMD_W-1:0]             req_command,
   input  logic [sppc_pkg::DELTA_W-1:0]           req_delta_time,
   input  logic [FRACTION_BITS:0]                 req_seek_position,
   input  sppc_pkg::ctrl_cmd_type                 cmd,
   output sppc_pkg::dp_status_type                status,
   output logic [FRACTION_BITS:0]                 rsp_position,
   output logic                                   rsp_playing,
   output logic                                   rsp_forward_dir,
   output logic [sppc_pkg::LOOP_W-1:0]            rsp_loop_total,
   output logic [sppc_pkg::EVENT_W-1:0]           rsp_event_res
);

   localparam int POS_W = FRACTION_BITS + 1;
   localparam int SPW   = FRACTION_BITS + 6;
   localparam int DIV_W = FRACTION_BITS + 5;
   localparam int REM_W = FRACTION_BITS + 2;
   localparam int SPAN_MIN_I = (1 << FRACTION_BITS) / 10000;

   localparam logic [POS_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic signed [SPW-1:0] ONE_S = SPW'(ONE);
   localparam logic signed [SPW-1:0] SPAN_MIN_S = SPW'(SPAN_MIN_I);
   localparam logic [sppc_pkg::PROD_W-1:0] INC_MAX =
      sppc_pkg::PROD_W'(64'd1 << (FRACTION_BITS + 4));

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [SPW-1:0] v);
      logic [POS_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > ONE_S) begin
         r = ONE;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   logic [POS_W-1:0]                   start_ff, start_in;
   logic [POS_W-1:0]                   end_ff, end_in;
   logic [sppc_pkg::MODE_W-1:0]        mode_ff, mode_in;
   logic [sppc_pkg::RATE_W-1:0]        rate_ff, rate_in;

   logic [POS_W-1:0]                   pos_ff, pos_in;
   logic                               playing_ff, playing_in;
   logic                               fwd_ff, fwd_in;
   logic [sppc_pkg::LOOP_W-1:0]        loops_ff, loops_in;
   logic [sppc_pkg::EVENT_W-1:0]       ev_ff, ev_in;

   logic [sppc_pkg::CMD_W-1:0]         op_ff;
   logic [POS_W-1:0]                   seek_ff;
   logic [sppc_pkg::PROD_W-1:0]        prod_ff;

   logic [DIV_W-1:0]                   div_ff, div_in;
   logic [REM_W-1:0]                   rem_ff, rem_in;
   logic [POS_W-1:0]                   span_ff, span_in;

   logic [POS_W-1:0]                   out_pos_ff;
   logic                               out_playing_ff;
   logic                               out_fwd_ff;
   logic [sppc_pkg::LOOP_W-1:0]        out_loops_ff;
   logic [sppc_pkg::EVENT_W-1:0]       out_ev_ff;

   logic [POS_W-1:0]                   csr_pos;
   logic [sppc_pkg::PROD_W-1:0]        inc_ext;
   logic [DIV_W-1:0]                   inc;
   logic signed [SPW-1:0]              inc_s, pos_s, s_s, e_s, span_raw;
   logic signed [SPW-1:0]              p_fwd, p_rev, p_move, overshoot, wrap_val;
   logic [POS_W-1:0]                   span;
   logic                               hit;
   logic [REM_W-1:0]                   rem_shift, rem_next;

   // config write, positions saturated to 1.0
   always_comb begin
      csr_pos  = (csr_wdata[POS_W-1:0] > ONE) ? ONE : csr_wdata[POS_W-1:0];
      start_in = start_ff;
      end_in   = end_ff;
      mode_in  = mode_ff;
      rate_in  = rate_ff;
      if (csr_we) begin
         unique case (csr_index)
            sppc_pkg::CSR_SEG_START: start_in = csr_pos;
            sppc_pkg::CSR_SEG_END:   end_in   = csr_pos;
            sppc_pkg::CSR_PLAY_MODE: mode_in  = csr_wdata[sppc_pkg::MODE_W-1:0];
            sppc_pkg::CSR_STEP_RATE: rate_in  = csr_wdata[sppc_pkg::RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // tick arithmetic
   always_comb begin
      inc_ext  = prod_ff >> FRACTION_BITS;
      inc      = (inc_ext > INC_MAX) ? INC_MAX[DIV_W-1:0] : inc_ext[DIV_W-1:0];
      inc_s    = $signed(SPW'(inc));
      pos_s    = $signed(SPW'(pos_ff));
      s_s      = $signed(SPW'(start_ff));
      e_s      = $signed(SPW'(end_ff));
      span_raw = e_s - s_s;
      span     = (span_raw <= SPAN_MIN_S) ? ONE : span_raw[POS_W-1:0];
      p_fwd    = pos_s + inc_s;
      p_rev    = pos_s - inc_s;
      hit      = fwd_ff ? (p_fwd >= e_s) : (p_rev <= s_s);
      p_move   = fwd_ff ? p_fwd : p_rev;
      overshoot = fwd_ff ? (p_fwd - e_s) : (s_s - p_rev);
      wrap_val = fwd_ff ? (s_s + $signed(SPW'(rem_ff))) : (e_s - $signed(SPW'(rem_ff)));
      rem_shift = {rem_ff[REM_W-2:0], div_ff[DIV_W-1]};
      rem_next  = (rem_shift >= REM_W'(span_ff)) ? (rem_shift - REM_W'(span_ff)) : rem_shift;
   end

   assign status.need_div = (op_ff == sppc_pkg::CMD_TICK) && playing_ff && hit &&
                            (mode_ff == sppc_pkg::MODE_LOOP);

   always_comb begin
      pos_in     = pos_ff;
      playing_in = playing_ff;
      fwd_in     = fwd_ff;
      loops_in   = loops_ff;
      ev_in      = ev_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      span_in    = span_ff;
      if (cmd.calc) begin
         ev_in = sppc_pkg::EV_NONE;
         unique case (op_ff)
            sppc_pkg::CMD_TICK: begin
               if (playing_ff) begin
                  if (!hit) begin
                     pos_in = sat_pos(p_move);
                  end else if (mode_ff == sppc_pkg::MODE_LOOP) begin
                     loops_in = loops_ff + 1'b1;
                     ev_in    = sppc_pkg::EV_LOOPED;
                     div_in   = overshoot[DIV_W-1:0];
                     rem_in   = '0;
                     span_in  = span;
                  end else if (mode_ff == sppc_pkg::MODE_PINGPONG) begin
                     pos_in   = fwd_ff ? end_ff : start_ff;
                     fwd_in   = !fwd_ff;
                     loops_in = loops_ff + 1'b1;
                     ev_in    = sppc_pkg::EV_LOOPED;
                  end else begin
                     pos_in     = fwd_ff ? end_ff : start_ff;
                     playing_in = 1'b0;
                     ev_in      = sppc_pkg::EV_ENDED;
                  end
               end
            end
            sppc_pkg::CMD_PLAY: begin
               if (!playing_ff) begin
                  playing_in = 1'b1;
                  ev_in      = sppc_pkg::EV_STARTED;
               end
            end
            sppc_pkg::CMD_PAUSE: playing_in = 1'b0;
            sppc_pkg::CMD_STOP: begin
               playing_in = 1'b0;
               pos_in     = start_ff;
               fwd_in     = 1'b1;
               loops_in   = '0;
            end
            sppc_pkg::CMD_FORWARD: begin
               fwd_in = 1'b1;
               if (!playing_ff) begin
                  playing_in = 1'b1;
                  ev_in      = sppc_pkg::EV_STARTED;
               end
            end
            sppc_pkg::CMD_REVERSE: begin
               fwd_in = 1'b0;
               if (!playing_ff) begin
                  playing_in = 1'b1;
                  ev_in      = sppc_pkg::EV_STARTED;
               end
            end
            sppc_pkg::CMD_SEEK: pos_in = (seek_ff > ONE) ? ONE : seek_ff;
            default: ;
         endcase
      end
      if (cmd.step) begin
         rem_in = rem_next;
         div_in = div_ff << 1;
      end
      if (cmd.wrap) begin
         pos_in = sat_pos(wrap_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         end_ff     <= ONE;
         mode_ff    <= sppc_pkg::MODE_ONCE;
         rate_ff    <= sppc_pkg::RATE_RESET;
         pos_ff     <= '0;
         playing_ff <= 1'b0;
         fwd_ff     <= 1'b1;
         loops_ff   <= '0;
         ev_ff      <= sppc_pkg::EV_NONE;
      end else begin
         start_ff   <= start_in;
         end_ff     <= end_in;
         mode_ff    <= mode_in;
         rate_ff    <= rate_in;
         pos_ff     <= pos_in;
         playing_ff <= playing_in;
         fwd_ff     <= fwd_in;
         loops_ff   <= loops_in;
         ev_ff      <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      span_ff <= span_in;
      if (cmd.load) begin
         op_ff   <= req_command;
         seek_ff <= req_seek_position;
         prod_ff <= {{sppc_pkg::RATE_W{1'b0}}, req_delta_time} *
                    {{sppc_pkg::DELTA_W{1'b0}}, rate_ff};
      end
      if (cmd.emit) begin
         out_pos_ff     <= pos_ff;
         out_playing_ff <= playing_ff;
         out_fwd_ff     <= fwd_ff;
         out_loops_ff   <= loops_ff;
         out_ev_ff      <= ev_ff;
      end
   end

   assign rsp_position    = out_pos_ff;
   assign rsp_playing     = out_playing_ff;
   assign rsp_forward_dir = out_fwd_ff;
   assign rsp_loop_total  = out_loops_ff;
   assign rsp_event_res   = out_ev_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= ONE) && (start_ff <= ONE) && (end_ff <= ONE))
      else $error("position or segment bound above 1.0");

   a_wrap_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.calc && status.need_div) |=>
         (ev_ff == sppc_pkg::EV_LOOPED) && (loops_ff == $past(loops_ff) + 1'b1))
      else $error("loop wrap did not count a loop");

endmodule

### hw/rtl/sppc_ctrl.sv
`timescale 1ns / 1ps

module sppc_ctrl #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  sppc_pkg::dp_status_type status,
   output sppc_pkg::ctrl_cmd_type  cmd
);

   localparam int DIV_W = FRACTION_BITS + 5;
   localparam int CNT_W = $clog2(DIV_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_WRAP,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.load = accept;
      cmd.calc = (state_ff == ST_CALC);
      cmd.step = (state_ff == ST_DIV);
      cmd.wrap = (state_ff == ST_WRAP);
      cmd.emit = (state_ff == ST_DONE) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (status.need_div) begin
               state_in = ST_DIV;
               count_in = CNT_W'(DIV_W - 1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (count_ff == '0) begin
               state_in = ST_WRAP;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_WRAP: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CALC))
      else $error("accepted command not evaluated next cycle");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRAP) |-> ($past(state_ff) == ST_DIV) && ($past(count_ff) == '0))
      else $error("wrap entered before remainder finished");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result loaded without raising valid");

endmodule

### tb/sppc_playback_checker.sv
`timescale 1ns / 1ps

module sppc_playback_checker #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [sppc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sppc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [sppc_pkg::CMD_W-1:0]      req_command,
   input  logic [sppc_pkg::DELTA_W-1:0]    req_delta_time,
   input  logic [FRACTION_BITS:0]          req_seek_position,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [FRACTION_BITS:0]          rsp_position,
   input  logic                            rsp_playing,
   input  logic                            rsp_forward_dir,
   input  logic [sppc_pkg::LOOP_W-1:0]     rsp_loop_total,
   input  logic [sppc_pkg::EVENT_W-1:0]    rsp_event_res,
   output int                              pending_count,
   output int                              fail_count
);

   localparam int     POS_W      = FRACTION_BITS + 1;
   localparam longint ONE        = longint'(1) << FRACTION_BITS;
   localparam longint INC_LIMIT  = longint'(1) << (FRACTION_BITS + 4);
   localparam longint SPAN_FLOOR = ONE / 10000;

   typedef struct packed {
      logic [POS_W-1:0]             position;
      logic                         playing;
      logic                         forward_dir;
      logic [sppc_pkg::LOOP_W-1:0]  loop_total;
      logic [sppc_pkg::EVENT_W-1:0] event_res;
   } playback_state_type;

   logic [POS_W-1:0]            seg_start;
   logic [POS_W-1:0]            seg_end;
   logic [sppc_pkg::MODE_W-1:0] mode;
   logic [sppc_pkg::RATE_W-1:0] rate;
   logic [POS_W-1:0]            pos;
   logic                        running;
   logic                        fwd;
   logic [sppc_pkg::LOOP_W-1:0] loops;
   int                          fails;

   playback_state_type expected_states[$];

   function automatic logic [POS_W-1:0] clamp_pos(input longint v);
      if (v < 0) return '0;
      if (v > ONE) return POS_W'(ONE);
      return POS_W'(v);
   endfunction

   function automatic logic [sppc_pkg::EVENT_W-1:0] begin_play();
      if (running) return sppc_pkg::EV_NONE;
      running = 1'b1;
      return sppc_pkg::EV_STARTED;
   endfunction

   function automatic logic [sppc_pkg::EVENT_W-1:0] apply_tick(
      input logic [sppc_pkg::DELTA_W-1:0] delta
   );
      logic [sppc_pkg::PROD_W-1:0]  prod;
      longint                       inc;
      longint                       s;
      longint                       e;
      longint                       span;
      longint                       p;
      logic [sppc_pkg::EVENT_W-1:0] ev;
      ev = sppc_pkg::EV_NONE;
      if (!running) return sppc_pkg::EV_NONE;
      prod = sppc_pkg::PROD_W'(delta) * sppc_pkg::PROD_W'(rate);
      inc = longint'(prod >> FRACTION_BITS);
      if (inc > INC_LIMIT) inc = INC_LIMIT;
      s = longint'(seg_start);
      e = longint'(seg_end);
      span = e - s;
      if (span <= SPAN_FLOOR) span = ONE;
      p = longint'(pos);
      if (fwd) begin
         p = p + inc;
         if (p >= e) begin
            if (mode == sppc_pkg::MODE_LOOP) begin
               p = s + (p - e) % span;
               loops = loops + 1'b1;
               ev = sppc_pkg::EV_LOOPED;
            end else if (mode == sppc_pkg::MODE_PINGPONG) begin
               p = e;
               fwd = 1'b0;
               loops = loops + 1'b1;
               ev = sppc_pkg::EV_LOOPED;
            end else begin
               p = e;
               running = 1'b0;
               ev = sppc_pkg::EV_ENDED;
            end
         end
      end else begin
         p = p - inc;
         if (p <= s) begin
            if (mode == sppc_pkg::MODE_LOOP) begin
               p = e - (s - p) % span;
               loops = loops + 1'b1;
               ev = sppc_pkg::EV_LOOPED;
            end else if (mode == sppc_pkg::MODE_PINGPONG) begin
               p = s;
               fwd = 1'b1;
               loops = loops + 1'b1;
               ev = sppc_pkg::EV_LOOPED;
            end else begin
               p = s;
               running = 1'b0;
               ev = sppc_pkg::EV_ENDED;
            end
         end
      end
      pos = clamp_pos(p);
      return ev;
   endfunction

   function automatic playback_state_type predict_command(
      input logic [sppc_pkg::CMD_W-1:0]   cmd,
      input logic [sppc_pkg::DELTA_W-1:0] delta,
      input logic [POS_W-1:0]             seek
   );
      playback_state_type           r;
      logic [sppc_pkg::EVENT_W-1:0] ev;
      ev = sppc_pkg::EV_NONE;
      case (cmd)
         sppc_pkg::CMD_TICK:    ev = apply_tick(delta);
         sppc_pkg::CMD_PLAY:    ev = begin_play();
         sppc_pkg::CMD_PAUSE:   running = 1'b0;
         sppc_pkg::CMD_STOP: begin
            running = 1'b0;
            pos = seg_start;
            fwd = 1'b1;
            loops = '0;
         end
         sppc_pkg::CMD_FORWARD: begin
            fwd = 1'b1;
            ev = begin_play();
         end
         sppc_pkg::CMD_REVERSE: begin
            fwd = 1'b0;
            ev = begin_play();
         end
         sppc_pkg::CMD_SEEK:    pos = clamp_pos(longint'(seek));
         default:               ;
      endcase
      r.position = pos;
      r.playing = running;
      r.forward_dir = fwd;
      r.loop_total = loops;
      r.event_res = ev;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      playback_state_type want;
      playback_state_type pred;
      if (reset) begin
         seg_start = '0;
         seg_end = POS_W'(ONE);
         mode = sppc_pkg::MODE_ONCE;
         rate = sppc_pkg::RATE_RESET;
         pos = '0;
         running = 1'b0;
         fwd = 1'b1;
         loops = '0;
         expected_states.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               sppc_pkg::CSR_SEG_START:
                  seg_start = clamp_pos(longint'(csr_wdata[POS_W-1:0]));
               sppc_pkg::CSR_SEG_END:
                  seg_end = clamp_pos(longint'(csr_wdata[POS_W-1:0]));
               sppc_pkg::CSR_PLAY_MODE: mode = csr_wdata[sppc_pkg::MODE_W-1:0];
               sppc_pkg::CSR_STEP_RATE: rate = csr_wdata[sppc_pkg::RATE_W-1:0];
               default:                 ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_states.size() == 0) begin
               $error("result transfer with no command outstanding, position %0d",
                      rsp_position);
               fails++;
            end else begin
               want = expected_states.pop_front();
               compare_field("position", 32'(want.position), 32'(rsp_position));
               compare_field("playing", 32'(want.playing), 32'(rsp_playing));
               compare_field("forward_dir", 32'(want.forward_dir), 32'(rsp_forward_dir));
               compare_field("loop_total", 32'(want.loop_total), 32'(rsp_loop_total));
               compare_field("event_res", 32'(want.event_res), 32'(rsp_event_res));
            end
         end
         if (req_valid && !req_stall) begin
            pred = predict_command(req_command, req_delta_time, req_seek_position);
            expected_states.insert(expected_states.size(), pred);
         end
      end
      pending_count <= expected_states.size();
      fail_count <= fails;
   end

endmodule

### tb/tb_segment_playback_position_counter_core.sv
`timescale 1ns / 1ps

module tb_segment_playback_position_counter_core;

   localparam int FRACTION_BITS = 16;
   localparam int POS_W         = FRACTION_BITS + 1;
   localparam int ONE           = 1 << FRACTION_BITS;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 32;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 100;

   localparam logic [sppc_pkg::CMD_W-1:0]  CMD_UNUSED  = 3'd7;
   localparam logic [sppc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [sppc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sppc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [sppc_pkg::CMD_W-1:0]      req_command = '0;
   logic [sppc_pkg::DELTA_W-1:0]    req_delta_time = '0;
   logic [POS_W-1:0]                req_seek_position = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [POS_W-1:0]                rsp_position;
   logic                            rsp_playing;
   logic                            rsp_forward_dir;
   logic [sppc_pkg::LOOP_W-1:0]     rsp_loop_total;
   logic [sppc_pkg::EVENT_W-1:0]    rsp_event_res;

   int pending_count;
   int fail_count;
   int tx_idle_pct = 12;
   int rx_idle_pct = 62;
   int quiet_cycles = 0;
   int commands_sent = 0;
   int settings_used = 0;

   segment_playback_position_counter_core #(
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_delta_time(req_delta_time),
      .req_seek_position(req_seek_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_position(rsp_position),
      .rsp_playing(rsp_playing),
      .rsp_forward_dir(rsp_forward_dir),
      .rsp_loop_total(rsp_loop_total),
      .rsp_event_res(rsp_event_res)
   );

   sppc_playback_checker #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_delta_time(req_delta_time),
      .req_seek_position(req_seek_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_position(rsp_position),
      .rsp_playing(rsp_playing),
      .rsp_forward_dir(rsp_forward_dir),
      .rsp_loop_total(rsp_loop_total),
      .rsp_event_res(rsp_event_res),
      .pending_count(pending_count),
      .fail_count(fail_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL segment_playback_position_counter_core");
         $finish;
      end
   end

   task automatic put_reg(input logic [sppc_pkg::CSR_IDX_W-1:0] idx,
                          input logic [sppc_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_registers(input logic [sppc_pkg::CSR_DATA_W-1:0] start_v, end_v,
                                    mode_v, rate_v);
      put_reg(sppc_pkg::CSR_SEG_START, start_v);
      put_reg(sppc_pkg::CSR_SEG_END, end_v);
      put_reg(sppc_pkg::CSR_PLAY_MODE, mode_v);
      put_reg(sppc_pkg::CSR_STEP_RATE, rate_v);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic send_command(input logic [sppc_pkg::CMD_W-1:0] cmd,
                               input logic [sppc_pkg::DELTA_W-1:0] delta,
                               input logic [POS_W-1:0] seek);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_delta_time <= delta;
      req_seek_position <= seek;
      do @(posedge clock); while (req_stall);
      commands_sent++;
   endtask

   // hold the sender off until every outstanding result has been transferred
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_phase(input int k);
      logic [sppc_pkg::CSR_DATA_W-1:0] s;
      logic [sppc_pkg::CSR_DATA_W-1:0] e;
      logic [sppc_pkg::CSR_DATA_W-1:0] m;
      logic [sppc_pkg::CSR_DATA_W-1:0] r;
      s = $urandom_range(0, ONE);
      e = $urandom_range(s, ONE);
      m = $urandom_range(0, 3);
      r = $urandom_range(2000, 60000);
      case (k % 8)
         0: begin
            s = 0;
            e = ONE;
            m = sppc_pkg::CSR_DATA_W'(sppc_pkg::MODE_LOOP);
         end
         1: m = sppc_pkg::CSR_DATA_W'(sppc_pkg::MODE_PINGPONG);
         2: begin
            e = $urandom_range(0, s);
            m = sppc_pkg::CSR_DATA_W'(sppc_pkg::MODE_LOOP);
         end
         3: e = s + $urandom_range(0, 7);
         4: r = 0;
         5: begin
            r = '1;
            m = sppc_pkg::CSR_DATA_W'(sppc_pkg::MODE_LOOP);
         end
         6: begin
            s = $urandom;
            e = $urandom;
            m = sppc_pkg::CSR_DATA_W'(MODE_UNUSED);
            r = $urandom;
         end
         default: begin
            s = ONE;
            e = ONE;
            m = sppc_pkg::CSR_DATA_W'(sppc_pkg::MODE_PINGPONG);
         end
      endcase
      m[sppc_pkg::CSR_DATA_W-1:sppc_pkg::MODE_W] =
         (sppc_pkg::CSR_DATA_W - sppc_pkg::MODE_W)'($urandom);
      program_registers(s, e, m, r);
   endtask

   task automatic send_random_command();
      logic [sppc_pkg::CMD_W-1:0]   cmd;
      logic [sppc_pkg::DELTA_W-1:0] delta;
      logic [POS_W-1:0]             seek;
      int                           pick;
      pick = $urandom_range(0, 99);
      if (pick < 62)      cmd = sppc_pkg::CMD_TICK;
      else if (pick < 70) cmd = sppc_pkg::CMD_PLAY;
      else if (pick < 76) cmd = sppc_pkg::CMD_FORWARD;
      else if (pick < 82) cmd = sppc_pkg::CMD_REVERSE;
      else if (pick < 86) cmd = sppc_pkg::CMD_PAUSE;
      else if (pick < 89) cmd = sppc_pkg::CMD_STOP;
      else if (pick < 97) cmd = sppc_pkg::CMD_SEEK;
      else                cmd = CMD_UNUSED;
      case ($urandom_range(0, 7))
         0:       delta = sppc_pkg::DELTA_W'($urandom_range(0, 255));
         1:       delta = sppc_pkg::DELTA_W'($urandom);
         2:       delta = $urandom_range(0, 1) ? '1 : '0;
         default: delta = sppc_pkg::DELTA_W'($urandom_range(8000, 40000));
      endcase
      if ($urandom_range(0, 3) == 0)
         seek = POS_W'($urandom);
      else
         seek = POS_W'($urandom_range(0, ONE));
      send_command(cmd, delta, seek);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: once mode, full segment, default rate
      send_command(sppc_pkg::CMD_TICK, '1, '0);
      send_command(sppc_pkg::CMD_PLAY, '0, '0);
      send_command(sppc_pkg::CMD_PLAY, '0, '0);
      send_command(sppc_pkg::CMD_TICK, '1, '0);
      send_command(sppc_pkg::CMD_SEEK, '0, '1);
      send_command(sppc_pkg::CMD_TICK, '0, '0);
      send_command(sppc_pkg::CMD_REVERSE, '0, '0);
      send_command(sppc_pkg::CMD_TICK, '1, '0);
      send_command(sppc_pkg::CMD_SEEK, '0, '0);
      send_command(sppc_pkg::CMD_TICK, '0, '0);
      send_command(sppc_pkg::CMD_PAUSE, '1, '1);
      send_command(sppc_pkg::CMD_STOP, '0, '0);
      send_command(CMD_UNUSED, '1, '1);
      send_command(sppc_pkg::CMD_FORWARD, '0, '0);
      wait_results_drained();

      program_registers(0, ONE, sppc_pkg::CSR_DATA_W'(sppc_pkg::MODE_PINGPONG), '1);
      send_command(sppc_pkg::CMD_TICK, '1, '0);
      send_command(sppc_pkg::CMD_TICK, '1, '0);
      send_command(sppc_pkg::CMD_TICK, sppc_pkg::DELTA_W'(1), '0);
      wait_results_drained();

      // start above end, wrap overshoots past full scale
      program_registers(60000, 1000, sppc_pkg::CSR_DATA_W'(sppc_pkg::MODE_LOOP), '1);
      send_command(sppc_pkg::CMD_TICK, '1, '0);
      send_command(sppc_pkg::CMD_REVERSE, '0, '0);
      send_command(sppc_pkg::CMD_TICK, '1, '0);
      wait_results_drained();

      program_registers(100, 20000, sppc_pkg::CSR_DATA_W'(MODE_UNUSED), 40000);
      send_command(sppc_pkg::CMD_FORWARD, '0, '0);
      send_command(sppc_pkg::CMD_TICK, '1, '0);
      send_command(sppc_pkg::CMD_STOP, '0, '0);
      wait_results_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < PHASES / 3) begin
            tx_idle_pct = 12;
            rx_idle_pct = 62;
         end else if (ph < 2 * PHASES / 3) begin
            tx_idle_pct = 62;
            rx_idle_pct = 12;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         configure_phase(ph);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_command();
            if (i == PHASE_ITEMS / 2 || $urandom_range(0, 199) == 0)
               wait_results_drained();
         end
         wait_results_drained();
      end

      $display("Covered %0d commands under %0d register settings, across all play modes,",
               commands_sent, settings_used);
      $display("with sender-side and receiver-side idling in turn and a stretch of neither.");
      if (fail_count == 0)
         $display("PASS segment_playback_position_counter_core");
      else
         $display("FAIL segment_playback_position_counter_core");
      $finish;
   end

endmodule
